### rtl/rpfc_pkg.sv
// Shared types and constants for the recent partner filter counter.
package rpfc_pkg;

  // Number of entries in each recent-partner list (1 to 32).
  localparam int LIST_DEPTH = 5;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam int ID_W    = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Statistic codes carried in the mode field
  localparam logic [1:0] MODE_TRADE = 2'd0;
  localparam logic [1:0] MODE_WON   = 2'd1;
  localparam logic [1:0] MODE_LOST  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_STATS_EN  = 2'd0;
  localparam logic [1:0] CFG_LINK_STAT = 2'd1;
  localparam logic [1:0] CFG_MAX_COUNT = 2'd2;

  localparam count_t MAX_COUNT_RST = 16'd999;

  typedef struct packed {
    logic [1:0] mode;
    id_t        partner_id;
  } in_item_t;

  typedef struct packed {
    logic   was_new;
    logic   counted;
    count_t count_value;
  } out_item_t;

  // Move-to-front update request to one list
  typedef struct packed {
    logic en;
    idx_t pos;
    id_t  id;
  } list_upd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

endpackage

### rtl/recent_partner_filter_counter_core.sv
// Top level: sequencer, shared id comparator, statistic counters and result register.
//
//  channel | ports                           | direction
//  input   | in_valid, in_stall, in_data     | item in (mode, partner_id)
//  result  | out_valid, out_stall, out_data  | item out (was_new, counted, count_value)
//  config  | cfg_we, cfg_index, cfg_data     | register write, no read-back
//
// An item is accepted in the idle state, then compared one list entry at a time by the single
// 32-bit comparator (up to LIST_DEPTH entries), then passes an update state and a result state.
// Disabled stats or mode three skip scan and update.
// Reset clears both lists, all counters and the registers (max_count to 999).
// in_stall is low only while the sequencer is idle; a stalled result holds the
// sequencer in its result state until the output register frees.
module recent_partner_filter_counter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rpfc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [rpfc_pkg::CFG_W-1:0] cfg_data
);
  import rpfc_pkg::*;

  // Configuration registers
  logic   stats_en_r;
  logic   link_stat_r;
  count_t max_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_en_r  <= 1'b0;
      link_stat_r <= 1'b0;
      max_count_r <= MAX_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATS_EN:  stats_en_r  <= cfg_data[0];
        CFG_LINK_STAT: link_stat_r <= cfg_data[0];
        CFG_MAX_COUNT: max_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  state_t    state_r, state_nxt;
  logic [1:0] mode_r;
  id_t       id_r;
  idx_t      idx_r;
  logic      fresh_r;
  logic      counted_r;
  count_t    trades_r, wins_r, losses_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  id_t       trade_rd, battle_rd, scan_rd;
  list_upd_t upd, trade_upd, battle_upd;
  logic      match, last_entry, is_trade, accept, out_free;
  count_t    sel_count;
  logic [COUNT_W:0] inc_sum;
  count_t    inc_val;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign is_trade  = (mode_r == MODE_TRADE);

  // Both lists share the scan index; the mode picks which one is compared
  rpfc_list u_trade_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx_r),
    .rd_data (trade_rd),
    .upd     (trade_upd)
  );

  rpfc_list u_battle_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx_r),
    .rd_data (battle_rd),
    .upd     (battle_upd)
  );

  // Shared comparator
  assign scan_rd    = is_trade ? trade_rd : battle_rd;
  assign match      = (scan_rd == id_r);
  assign last_entry = (idx_r == IDX_W'(LIST_DEPTH - 1));

  // List update: position is the hit index, or the last slot on a miss
  always_comb begin
    upd.en  = (state_r == ST_UPDATE);
    upd.pos = idx_r;
    upd.id  = id_r;
    trade_upd     = upd;
    battle_upd    = upd;
    trade_upd.en  = upd.en && is_trade;
    battle_upd.en = upd.en && !is_trade;
  end

  // Counter of the current statistic; mode three reads as zero
  always_comb begin
    case (mode_r)
      MODE_TRADE: sel_count = trades_r;
      MODE_WON:   sel_count = wins_r;
      MODE_LOST:  sel_count = losses_r;
      default:    sel_count = '0;
    endcase
  end

  // Saturating increment
  assign inc_sum = {1'b0, sel_count} + (COUNT_W+1)'(1);
  assign inc_val = (inc_sum > {1'b0, max_count_r}) ? max_count_r : inc_sum[COUNT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stats_en_r && (in_data.mode != MODE_NONE)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (match || last_entry) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item registers and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      fresh_r   <= 1'b0;
      counted_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r    <= in_data.mode;
        id_r      <= in_data.partner_id;
        idx_r     <= '0;
        fresh_r   <= 1'b0;
        counted_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (!match && last_entry) begin
          fresh_r <= 1'b1;
        end else if (!match) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end else if (state_r == ST_UPDATE) begin
        counted_r <= fresh_r && link_stat_r;
      end
    end
  end

  // Statistic counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trades_r <= '0;
      wins_r   <= '0;
      losses_r <= '0;
    end else if ((state_r == ST_UPDATE) && fresh_r && link_stat_r) begin
      case (mode_r)
        MODE_TRADE: trades_r <= inc_val;
        MODE_WON:   wins_r   <= inc_val;
        MODE_LOST:  losses_r <= inc_val;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESULT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RESULT) && out_free) begin
      out_data_r.was_new     <= fresh_r;
      out_data_r.counted     <= counted_r;
      out_data_r.count_value <= sel_count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/rpfc_list.sv
// One move-to-front list of recent partner ids with an indexed read port.
module rpfc_list (
  input  logic              clk,
  input  logic              rst_n,
  input  rpfc_pkg::idx_t    rd_idx,
  output rpfc_pkg::id_t     rd_data,
  input  rpfc_pkg::list_upd_t upd
);
  import rpfc_pkg::*;

  id_t entry_r [LIST_DEPTH];

  // Scan read port
  assign rd_data = entry_r[rd_idx];

  // Entries up to the update position slide down one place, id goes to the front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        entry_r[k] <= '0;
      end
    end else if (upd.en) begin
      entry_r[0] <= upd.id;
      for (int k = 1; k < LIST_DEPTH; k++) begin
        if (IDX_W'(k) <= upd.pos) begin
          entry_r[k] <= entry_r[k-1];
        end
      end
    end
  end

endmodule

### test/tb.sv
// Self-checking testbench for the recent partner filter counter core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpfc_pkg::*;

  // Mode code with no statistic behind it
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 16;

  // Tracks partner lists and counters, keeps the expected reports in order
  class partner_stats_book;
    id_t       lists[2][LIST_DEPTH];  // 0: trades, 1: battles
    count_t    tally[3];              // indexed by mode
    bit        enabled;
    bit        link_stat;
    count_t    ceiling;
    out_item_t pending_reports[$];
    int        errors;
    int        checked;
    int        new_partners;
    int        bumps;
    int        clamps;
    int        no_stat_events;

    function new();
      int k;
      for (k = 0; k < LIST_DEPTH; k++) begin
        lists[0][k] = '0;
        lists[1][k] = '0;
      end
      tally[0] = '0;
      tally[1] = '0;
      tally[2] = '0;
      enabled = 1'b0;
      link_stat = 1'b0;
      ceiling = MAX_COUNT_RST;
      errors = 0;
      checked = 0;
      new_partners = 0;
      bumps = 0;
      clamps = 0;
      no_stat_events = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_STATS_EN:  enabled = val[0];
        CFG_LINK_STAT: link_stat = val[0];
        CFG_MAX_COUNT: ceiling = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Move-to-front touch of one list; returns 1 when the id was absent
    function bit touch_list(int which, id_t id);
      int  pos;
      int  k;
      bit  absent;
      pos = LIST_DEPTH - 1;
      absent = 1'b1;
      for (k = 0; k < LIST_DEPTH; k++) begin
        if (absent && lists[which][k] == id) begin
          pos = k;
          absent = 1'b0;
        end
      end
      for (k = pos; k > 0; k--)
        lists[which][k] = lists[which][k-1];
      lists[which][0] = id;
      return absent;
    endfunction

    // Accepted input item: update state and queue the expected report
    function void note_event(in_item_t it);
      out_item_t   rpt;
      int          m;
      logic [16:0] bumped;
      rpt = '0;
      m = int'(it.mode);
      if (it.mode == MODE_NONE) begin
        no_stat_events++;
        pending_reports.push_back(rpt);
        return;
      end
      if (enabled) begin
        rpt.was_new = touch_list((it.mode == MODE_TRADE) ? 0 : 1, it.partner_id);
        if (rpt.was_new)
          new_partners++;
        if (rpt.was_new && link_stat) begin
          bumped = {1'b0, tally[m]} + 17'd1;
          if (bumped > {1'b0, ceiling}) begin
            bumped = {1'b0, ceiling};
            clamps++;
          end
          tally[m] = bumped[COUNT_W-1:0];
          rpt.counted = 1'b1;
          bumps++;
        end
      end
      rpt.count_value = tally[m];
      pending_reports.push_back(rpt);
    endfunction

    // Accepted result item: compare with the oldest expected report
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        $error("result with no event pending: was_new=%0d counted=%0d count_value=%0d",
               got.was_new, got.counted, got.count_value);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got.was_new !== want.was_new) begin
        $error("was_new: expected %0d, got %0d", want.was_new, got.was_new);
        errors++;
      end
      if (got.counted !== want.counted) begin
        $error("counted: expected %0d, got %0d", want.counted, got.counted);
        errors++;
      end
      if (got.count_value !== want.count_value) begin
        $error("count_value: expected %0d, got %0d", want.count_value, got.count_value);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  partner_stats_book book;
  int long_holds_asked;
  int settings_used;

  recent_partner_filter_counter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: checks accepted items and stalls on its own pattern
  initial begin : result_sink
    int cyc;
    int pat;
    int hold_left;
    int holds_done;
    cyc = 0;
    pat = 0;
    hold_left = 0;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        book.check_result(out_data);
      cyc++;
      if (cyc % 97 == 0)
        pat = $urandom_range(0, 3);
      if (holds_done != long_holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (pat)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_event(input logic [1:0] mode, input id_t id);
    in_item_t it;
    it.mode = mode;
    it.partner_id = id;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    book.note_event(it);
  endtask

  task automatic gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every report, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_one(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    book.write_reg(idx, val);
  endtask

  // Program all three registers; only called while the block is idle
  task automatic program_regs(input bit en, input bit link, input count_t ceil);
    write_one(CFG_STATS_EN, CFG_W'(en));
    write_one(CFG_LINK_STAT, CFG_W'(link));
    write_one(CFG_MAX_COUNT, CFG_W'(ceil));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Random events: mostly a small pool of ids so lists see hits and evictions
  task automatic run_phase(input int n_items, input bit with_gaps, input bit pressure);
    id_t        pool[8];
    int         k;
    int         burst;
    int         r;
    logic [1:0] mode;
    id_t        id;
    for (k = 0; k < 8; k++)
      pool[k] = $urandom();
    burst = $urandom_range(1, 20);
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      mode = (r < 8) ? MODE_NONE : 2'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 65)
        id = pool[$urandom_range(0, 7)];
      else if (r < 90)
        id = $urandom();
      else if (r < 95)
        id = '0;
      else
        id = '1;
      if (pressure && k == n_items / 3)
        long_holds_asked++;
      send_event(mode, id);
      if (with_gaps) begin
        burst--;
        if (burst == 0) begin
          gap($urandom_range(1, 10));
          burst = $urandom_range(1, 20);
        end
      end
    end
  endtask

  initial begin : stimulus
    int     p;
    bit     en;
    bit     link;
    count_t ceil;
    book = new();
    long_holds_asked = 0;
    settings_used = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_STATS_EN;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: stats off, every event leaves state alone
    send_event(MODE_TRADE, 32'h0000_0000);
    send_event(MODE_WON, 32'hFFFF_FFFF);
    send_event(MODE_NONE, 32'h0000_007B);
    drain();

    // Stats on and counting: zero hits on a fresh list, eviction of the oldest
    program_regs(1'b1, 1'b1, MAX_COUNT_RST);
    send_event(MODE_TRADE, 32'h0000_0000);
    send_event(MODE_TRADE, 32'hFFFF_FFFF);
    send_event(MODE_TRADE, 32'h0000_0001);
    send_event(MODE_TRADE, 32'h0000_0002);
    send_event(MODE_TRADE, 32'h0000_0003);
    send_event(MODE_TRADE, 32'h0000_0004);
    send_event(MODE_TRADE, 32'h0000_0005);
    send_event(MODE_TRADE, 32'hFFFF_FFFF);
    send_event(MODE_TRADE, 32'h0000_0003);
    // won and lost battles share one list
    send_event(MODE_WON, 32'hFFFF_FFFF);
    send_event(MODE_LOST, 32'hFFFF_FFFF);
    send_event(MODE_LOST, 32'hAAAA_AAAA);
    send_event(MODE_WON, 32'h0000_0000);
    send_event(MODE_NONE, 32'h5555_5555);
    drain();

    // Ceiling of one lowers a counter that is already above it
    program_regs(1'b1, 1'b1, 16'd1);
    send_event(MODE_TRADE, 32'h0000_0077);
    send_event(MODE_WON, 32'h0000_1234);
    drain();

    // Not a link-stat card: newness still reported, counters frozen
    program_regs(1'b1, 1'b0, 16'd65534);
    send_event(MODE_TRADE, 32'h8000_0001);
    send_event(MODE_LOST, 32'hAAAA_AAAA);
    drain();

    for (p = 0; p < 9; p++) begin
      en = (p != 4);
      link = (p % 3 != 2);
      case (p % 5)
        0: ceil = 16'd65534;
        1: ceil = 16'd1;
        2: ceil = count_t'($urandom_range(2, 20));
        3: ceil = MAX_COUNT_RST;
        default: ceil = count_t'($urandom_range(1, 65534));
      endcase
      program_regs(en, link, ceil);
      run_phase(65, (p != 2 && p != 6), (p == 2));
      drain();
    end

    $display("tb: %0d reports checked across %0d register settings, %0d no-stat events",
             book.checked, settings_used, book.no_stat_events);
    $display("tb: %0d new partners, %0d counter increments, %0d of them clamped",
             book.new_partners, book.bumps, book.clamps);
    if (book.errors == 0 && book.pending_reports.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
